// File: rtl/krm_pkg.sv
// Package for the knock rhythm matcher: constants, register codes, types.
`default_nettype none
package krm_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 16;
  localparam int unsigned NUM_PATTERNS_DEF  = 4;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PAT_W   = 21;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned SEQ_LSB = 5;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned CFG_A_W = 3;

  localparam logic [TIME_W-1:0] MIN_START = 32'h7FFF_FFFF;

  typedef enum logic [CFG_A_W-1:0] {
    REG_MIN_INTERVAL = 3'd0,
    REG_TOO_LONG     = 3'd1,
    REG_DEADTIME     = 3'd2,
    REG_PATTERN_0    = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_EVAL,
    S_CLASS,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/krm_in_if.sv
// Knock input channel: valid/ready with the knock timestamp.
`default_nettype none
interface krm_in_if;
  import krm_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] knock_time;

  modport source (output valid, output knock_time, input ready);
  modport sink   (input valid, input knock_time, output ready);
endinterface
`default_nettype wire

// File: rtl/krm_out_if.sv
// Result channel: valid/ready with accepted, matched and pattern index.
`default_nettype none
interface krm_out_if;
  import krm_pkg::*;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             matched;
  logic [IDX_W-1:0] pattern_index;

  modport source (output valid, output accepted, output matched, output pattern_index,
                  input ready);
  modport sink   (input valid, input accepted, input matched, input pattern_index,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/knock_rhythm_matcher_unit.sv
// Knock rhythm matcher: gap history in a ring memory, sequential pattern search.
//
//   channel  | dir | transfer when        | payload
//   ---------+-----+----------------------+------------------------------------
//   knock    | in  | valid & ready        | knock_time
//   result   | out | valid & ready        | accepted, matched, pattern_index
//   cfg      | in  | cfg_write            | cfg_index, cfg_data
//
// A rejected knock yields its result at the transfer edge. An appended knock
// walks the patterns from the top until one matches: per pattern a setup
// state, plus for a nonzero length a scan pass over the history memory, an
// evaluation state and, if the gaps pass it, a classify pass; then the result
// is posted. Both passes go through the single read port. Reset clears the
// history valid bits. A result waiting on the output holds the engine in its
// final state; knock.ready follows the slot while idle.
`default_nettype none
module knock_rhythm_matcher_unit
  import krm_pkg::*;
#(
  parameter int unsigned HistoryDepth = HISTORY_DEPTH_DEF,
  parameter int unsigned NumPatterns  = NUM_PATTERNS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  krm_in_if.sink                  knock,
  krm_out_if.source               result,
  input  wire logic               cfg_write,
  input  wire logic [CFG_A_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(HistoryDepth);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HistoryDepth - 1);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(HistoryDepth);

  // configuration
  logic [TIME_W-1:0] min_interval, too_long, deadtime;
  logic [PAT_W-1:0]  patterns [NumPatterns];

  // history memory and valid bits
  logic [TIME_W-1:0] mem [HistoryDepth];
  logic [HistoryDepth-1:0] hvalid;
  logic [TIME_W-1:0] rdata;
  logic              rvld;
  logic              rd_en, rd_pend;
  logic              mem_we;

  // control and datapath registers
  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     addr, addr_next;
  logic [TIME_W-1:0] last_knock, last_knock_next;
  logic [TIME_W-1:0] match_time, match_time_next;
  logic              appends_en, appends_en_next;
  logic [IDX_W-1:0]  pat_n, pat_n_next;
  logic [LEN_W-1:0]  len_q, len_next;
  logic [LEN_W-1:0]  issue_cnt, issue_cnt_next;
  logic [LEN_W-1:0]  proc_i, proc_i_next;
  logic [TIME_W-1:0] lo, lo_next, hi, hi_next, mid, mid_next;
  logic              bad, bad_next, mism, mism_next;
  logic              found, found_next;
  logic              out_valid, out_valid_next;
  logic              out_acc, out_acc_next, out_mat, out_mat_next;
  logic [IDX_W-1:0]  out_idx, out_idx_next;

  // combinational helpers
  logic              slot_free, eligible, append, go_next, last_proc, cls, mm;
  logic [TIME_W-1:0] gap, g;
  logic [AW-1:0]     head_inc, addr_dec;
  logic [PAT_W-1:0]  cur_pat;
  logic [LEN_W-1:0]  len_raw, len_sat, want_pos;
  logic [SEQ_W-1:0]  seq;
  logic [TIME_W:0]   mid_sum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= 32'd100;
      too_long     <= 32'd2000;
      deadtime     <= 32'd3000;
      for (int k = 0; k < NumPatterns; k++) begin
        patterns[k] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_MIN_INTERVAL) min_interval <= cfg_data;
      if (cfg_index == REG_TOO_LONG)     too_long     <= cfg_data;
      if (cfg_index == REG_DEADTIME)     deadtime     <= cfg_data;
      for (int k = 0; k < NumPatterns; k++) begin
        if (cfg_index == CFG_A_W'(REG_PATTERN_0 + k)) patterns[k] <= cfg_data[PAT_W-1:0];
      end
    end
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[head_inc] <= gap;
    if (rd_en) begin
      rdata <= mem[addr];
      rvld  <= hvalid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
    end else if (mem_we) begin
      hvalid[head_inc] <= 1'b1;
    end
  end

  assign slot_free = !out_valid || result.ready;
  assign gap       = knock.knock_time - last_knock;
  assign eligible  = appends_en || ((knock.knock_time - match_time) >= deadtime);
  assign append    = eligible && (gap > min_interval);
  assign head_inc  = (head == LAST_ADDR) ? '0 : head + 1'b1;
  assign addr_dec  = (addr == '0) ? LAST_ADDR : addr - 1'b1;
  assign cur_pat   = patterns[pat_n];
  assign len_raw   = cur_pat[LEN_W-1:0];
  assign len_sat   = (len_raw > DEPTH_LEN) ? DEPTH_LEN : len_raw;
  assign seq       = cur_pat[SEQ_LSB +: SEQ_W];
  assign g         = rvld ? rdata : '0;
  assign last_proc = (proc_i == len_q - 1'b1);
  assign want_pos  = len_q - 1'b1 - proc_i;
  assign cls       = (g >= mid);
  assign mm        = mism | (cls != seq[want_pos[3:0]]);
  assign mid_sum   = {1'b0, hi} + {1'b0, lo};

  always_comb begin
    state_next      = state;
    head_next       = head;
    addr_next       = addr;
    last_knock_next = last_knock;
    match_time_next = match_time;
    appends_en_next = appends_en;
    pat_n_next      = pat_n;
    len_next        = len_q;
    issue_cnt_next  = issue_cnt;
    proc_i_next     = proc_i;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    bad_next        = bad;
    mism_next       = mism;
    found_next      = found;
    out_valid_next  = out_valid;
    out_acc_next    = out_acc;
    out_mat_next    = out_mat;
    out_idx_next    = out_idx;
    knock.ready     = 1'b0;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    go_next         = 1'b0;

    if (out_valid && result.ready) out_valid_next = 1'b0;

    unique case (state)
      S_IDLE: begin
        knock.ready = slot_free;
        if (knock.valid && slot_free) begin
          appends_en_next = eligible;
          if (append) begin
            mem_we          = 1'b1;
            head_next       = head_inc;
            last_knock_next = knock.knock_time;
            pat_n_next      = IDX_W'(NumPatterns - 1);
            state_next      = S_START;
          end else begin
            out_valid_next = 1'b1;
            out_acc_next   = 1'b0;
            out_mat_next   = 1'b0;
            out_idx_next   = '0;
          end
        end
      end
      S_START: begin
        if (len_raw == '0) begin
          go_next = 1'b1;
        end else begin
          len_next       = len_sat;
          issue_cnt_next = '0;
          proc_i_next    = '0;
          addr_next      = head;
          lo_next        = MIN_START;
          hi_next        = '0;
          bad_next       = 1'b0;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_cnt < len_q) begin
          rd_en          = 1'b1;
          issue_cnt_next = issue_cnt + 1'b1;
          addr_next      = addr_dec;
        end
        if (rd_pend) begin
          if (g > too_long) bad_next = 1'b1;
          if (g > hi)       hi_next  = g;
          if (g < lo)       lo_next  = g;
          proc_i_next = proc_i + 1'b1;
          if (last_proc) state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (bad || (hi < lo) || ((hi - lo) < min_interval)) begin
          go_next = 1'b1;
        end else begin
          mid_next       = mid_sum[TIME_W:1];
          issue_cnt_next = '0;
          proc_i_next    = '0;
          addr_next      = head;
          mism_next      = 1'b0;
          state_next     = S_CLASS;
        end
      end
      S_CLASS: begin
        if (issue_cnt < len_q) begin
          rd_en          = 1'b1;
          issue_cnt_next = issue_cnt + 1'b1;
          addr_next      = addr_dec;
        end
        if (rd_pend) begin
          mism_next   = mm;
          proc_i_next = proc_i + 1'b1;
          if (last_proc) begin
            if (!mm) begin
              found_next = 1'b1;
              state_next = S_DONE;
            end else begin
              go_next = 1'b1;
            end
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_acc_next   = 1'b1;
          out_mat_next   = found;
          out_idx_next   = found ? pat_n : '0;
          if (found) begin
            appends_en_next = 1'b0;
            match_time_next = last_knock;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // move on to the next lower pattern, or finish without a match
    if (go_next) begin
      if (pat_n == '0) begin
        found_next = 1'b0;
        state_next = S_DONE;
      end else begin
        pat_n_next = pat_n - 1'b1;
        state_next = S_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      last_knock <= '0;
      match_time <= '0;
      appends_en <= 1'b1;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      last_knock <= last_knock_next;
      match_time <= match_time_next;
      appends_en <= appends_en_next;
      out_valid  <= out_valid_next;
      rd_pend    <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    addr      <= addr_next;
    pat_n     <= pat_n_next;
    len_q     <= len_next;
    issue_cnt <= issue_cnt_next;
    proc_i    <= proc_i_next;
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    bad       <= bad_next;
    mism      <= mism_next;
    found     <= found_next;
    out_acc   <= out_acc_next;
    out_mat   <= out_mat_next;
    out_idx   <= out_idx_next;
  end

  assign result.valid         = out_valid;
  assign result.accepted      = out_acc;
  assign result.matched       = out_mat;
  assign result.pattern_index = out_idx;

  // a match is only ever reported for an appended knock
  a_match_needs_append: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.matched |-> result.accepted)
    else $error("match reported on a rejected knock");

  // read data only returns while a pass is walking the history
  a_read_in_pass: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_SCAN || state == S_CLASS))
    else $error("history read data outside a scan pass");

  // posting a match blocks further appends
  a_match_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && slot_free && found |=> !appends_en && result.matched)
    else $error("match posted without blocking appends");

  // an appended knock leaves its gap marked valid at the new head
  a_append_writes: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && knock.valid && knock.ready && append |=> hvalid[head])
    else $error("appended gap not recorded");

endmodule
`default_nettype wire

// File: dv/knock_rhythm_matcher_unit_tb.sv
// Self-checking testbench for the knock rhythm matcher: directed table, then random rhythms.
`default_nettype none
module knock_rhythm_matcher_unit_tb;
  import krm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HD         = HISTORY_DEPTH_DEF;
  localparam int unsigned NP         = NUM_PATTERNS_DEF;
  localparam int          NUM_PHASES = 11;
  localparam int          STALL_CYCLES = 600;
  localparam int          TAIL_CYCLES  = 300;
  localparam int          MAX_PRINTS   = 40;

  localparam logic [CFG_A_W-1:0] REG_PATTERN_1 = REG_PATTERN_0 + 3'd1;
  localparam logic [CFG_A_W-1:0] REG_PATTERN_2 = REG_PATTERN_0 + 3'd2;
  localparam logic [CFG_A_W-1:0] REG_PATTERN_3 = REG_PATTERN_0 + 3'd3;

  typedef struct packed {
    logic             accepted;
    logic             matched;
    logic [IDX_W-1:0] pattern_index;
  } knock_res_t;

  localparam knock_res_t RES_REJECT = 4'b0000;
  localparam knock_res_t RES_APPEND = 4'b1000;

  typedef struct packed {
    logic               is_write;
    logic [CFG_A_W-1:0] reg_idx;
    logic [TIME_W-1:0]  value;
    logic               typed;
    knock_res_t         res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic               cfg_write;
  logic [CFG_A_W-1:0] cfg_index;
  logic [TIME_W-1:0]  cfg_data;

  krm_in_if  kn_if ();
  krm_out_if res_if ();

  knock_rhythm_matcher_unit uut (
    .clk       (clk),
    .rst       (rst),
    .knock     (kn_if),
    .result    (res_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // matcher state as predicted
  logic [TIME_W-1:0] gap_hist [HD];
  logic [TIME_W-1:0] last_ts;
  logic [TIME_W-1:0] match_ts;
  logic              armed;
  logic [TIME_W-1:0] cfg_min_gap;
  logic [TIME_W-1:0] cfg_too_long;
  logic [TIME_W-1:0] cfg_dead;
  logic [PAT_W-1:0]  cfg_pat [NP];

  knock_res_t  due_outcomes [$];
  stim_row_t   directed [$];
  knock_res_t  seen;
  knock_res_t  want;
  logic [TIME_W-1:0] sent_ts;
  int  errors = 0;
  int  items_sent = 0;
  int  n_appended = 0;
  int  n_matched = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic void model_reset();
    cfg_min_gap  = 32'd100;
    cfg_too_long = 32'd2000;
    cfg_dead     = 32'd3000;
    for (int p = 0; p < NP; p++) cfg_pat[p] = '0;
    for (int i = 0; i < HD; i++) gap_hist[i] = '0;
    last_ts  = '0;
    match_ts = '0;
    armed    = 1'b1;
  endfunction

  function automatic void model_write(input logic [CFG_A_W-1:0] idx,
                                      input logic [TIME_W-1:0] value);
    case (idx)
      REG_MIN_INTERVAL: cfg_min_gap  = value;
      REG_TOO_LONG:     cfg_too_long = value;
      REG_DEADTIME:     cfg_dead     = value;
      default: begin
        if (idx >= REG_PATTERN_0 && idx - REG_PATTERN_0 < NP)
          cfg_pat[idx - REG_PATTERN_0] = value[PAT_W-1:0];
      end
    endcase
  endfunction

  // does the newest window of gaps classify into this pattern's long/short sequence
  function automatic bit rhythm_fits(input logic [PAT_W-1:0] pat);
    int unsigned       len;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [TIME_W:0]   mid;
    bit                cls;
    len = 32'(pat[LEN_W-1:0]);
    seq = pat[SEQ_LSB +: SEQ_W];
    if (len == 0) return 1'b0;
    if (len > HD) len = HD;
    lo = MIN_START;
    hi = '0;
    for (int i = 0; i < len; i++) begin
      if (gap_hist[i] > cfg_too_long) return 1'b0;
      if (gap_hist[i] > hi) hi = gap_hist[i];
      if (gap_hist[i] < lo) lo = gap_hist[i];
    end
    if (hi < lo || hi - lo < cfg_min_gap) return 1'b0;
    mid = ({1'b0, hi} + {1'b0, lo}) >> 1;
    for (int i = 0; i < len; i++) begin
      cls = ({1'b0, gap_hist[i]} >= mid);
      if (cls != seq[(len - 1 - i) & 15]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic knock_res_t predict_knock(input logic [TIME_W-1:0] ts);
    knock_res_t        r;
    logic [TIME_W-1:0] gap;
    r = RES_REJECT;
    if (!armed && (ts - match_ts) >= cfg_dead) armed = 1'b1;
    if (!armed) return r;
    gap = ts - last_ts;
    if (gap <= cfg_min_gap) return r;
    for (int i = HD - 1; i > 0; i--) gap_hist[i] = gap_hist[i-1];
    gap_hist[0] = gap;
    last_ts = ts;
    r.accepted = 1'b1;
    for (int n = NP - 1; n >= 0; n--) begin
      if (rhythm_fits(cfg_pat[n])) begin
        armed = 1'b0;
        match_ts = ts;
        r.matched = 1'b1;
        r.pattern_index = n[IDX_W-1:0];
        break;
      end
    end
    return r;
  endfunction

  function automatic void add_knock(input logic [TIME_W-1:0] ts, input logic typed,
                                    input knock_res_t res);
    directed.push_back({1'b0, {CFG_A_W{1'b0}}, ts, typed, res});
  endfunction

  function automatic void add_write(input logic [CFG_A_W-1:0] idx,
                                    input logic [TIME_W-1:0] value);
    directed.push_back({1'b1, idx, value, 1'b0, RES_REJECT});
  endfunction

  function automatic void build_directed();
    add_knock(32'd0,          1'b1, RES_REJECT);  // zero gap from reset time
    add_knock(32'd100,        1'b1, RES_REJECT);  // gap equal to min_interval
    add_knock(32'd101,        1'b1, RES_APPEND);
    add_knock(32'hFFFF_FFFF,  1'b1, RES_APPEND);
    add_knock(32'd200,        1'b1, RES_APPEND);  // timestamp wraps
    add_write(REG_PATTERN_3, 32'h001F_FFFF);      // length saturates, all long
    add_write(REG_PATTERN_2, 32'h0000_0022);      // long then short
    add_write(REG_PATTERN_1, 32'h0001_FFE0);      // zero length, never matches
    add_write(REG_PATTERN_0, 32'h0000_0000);
    add_knock(32'd1000,       1'b0, RES_REJECT);
    add_knock(32'd1300,       1'b0, RES_REJECT);
    add_knock(32'd1500,       1'b0, RES_REJECT);  // inside deadtime
    add_knock(32'd4299,       1'b0, RES_REJECT);  // one tick short of deadtime
    add_knock(32'd4300,       1'b0, RES_REJECT);
    add_write(REG_DEADTIME,   32'd0);
    add_write(REG_TOO_LONG,   32'hFFFF_FFFF);
    add_write(REG_PATTERN_0,  32'h0000_0021);     // single long gap
    add_knock(32'h9000_10CC,  1'b0, RES_REJECT);  // gap above the running-min start
    add_knock(32'h9000_1194,  1'b0, RES_REJECT);  // right after a match, no deadtime
    add_write(REG_MIN_INTERVAL, 32'hFFFF_FFFF);
    add_knock(32'h1234_5678,  1'b1, RES_REJECT);
    add_write(REG_MIN_INTERVAL, 32'd0);
    add_knock(32'h9000_1194,  1'b1, RES_REJECT);
    add_knock(32'h9000_1195,  1'b0, RES_REJECT);
  endfunction

  function automatic logic [PAT_W-1:0] random_pattern();
    logic [31:0]      rnd;
    logic [LEN_W-1:0] len;
    int unsigned      pick;
    rnd  = $urandom;
    pick = $urandom_range(99);
    if (pick < 8)       len = '0;
    else if (pick < 16) len = LEN_W'($urandom_range(17, 31));
    else                len = LEN_W'($urandom_range(1, HD));
    return {rnd[SEQ_W-1:0], len};
  endfunction

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [TIME_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    model_write(idx, value);
  endtask

  // park the input and wait until every predicted result has been taken
  task automatic settle();
    cfg_write   <= 1'b0;
    kn_if.valid <= 1'b0;
    @(posedge clk);
    while (due_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic send_knock(input logic [TIME_W-1:0] ts, input logic typed,
                            input knock_res_t typed_res);
    knock_res_t r;
    while (!no_idle && $urandom_range(99) < 38) begin
      kn_if.valid <= 1'b0;
      @(posedge clk);
    end
    kn_if.valid      <= 1'b1;
    kn_if.knock_time <= ts;
    @(posedge clk);
    while (!kn_if.ready) @(posedge clk);
    r = predict_knock(ts);
    due_outcomes.push_back(typed ? typed_res : r);
    sent_ts = ts;
    items_sent++;
  endtask

  task automatic setup_phase(input int ph);
    logic [TIME_W-1:0] mg;
    logic [TIME_W-1:0] tl;
    logic [TIME_W-1:0] dt;
    logic [31:0]       rnd;
    logic [PAT_W-1:0]  pats [NP];
    rnd = $urandom;
    mg  = $urandom_range(20, 150);
    tl  = $urandom_range(1500, 4000);
    dt  = $urandom_range(0, 5000);
    for (int p = 0; p < NP; p++) pats[p] = random_pattern();
    case (ph)
      0: begin
        mg = 32'd100;
        tl = 32'd2000;
        dt = 32'd3000;
      end
      4: begin
        mg = '0;
        tl = '1;
        dt = '0;
      end
      5: begin
        mg = '1;
        pats[3] = '1;
        pats[0] = '0;
      end
      6: tl = '0;
      7: dt = '1;
      8: begin
        pats[3] = '1;
        pats[1] = {rnd[SEQ_W-1:0], 5'd31};
      end
      default: ;
    endcase
    write_reg(REG_MIN_INTERVAL, mg);
    write_reg(REG_TOO_LONG, tl);
    write_reg(REG_DEADTIME, dt);
    for (int p = 0; p < NP; p++) begin
      rnd = $urandom;
      write_reg(CFG_A_W'(REG_PATTERN_0 + p), {rnd[TIME_W-1:PAT_W], pats[p]});
    end
  endtask

  // a pause long enough to clear deadtime, then one gap per pattern step, oldest first
  task automatic play_rhythm(input logic [PAT_W-1:0] pat);
    int unsigned       len;
    int unsigned       mg;
    int unsigned       spoil;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] g;
    logic [31:0]       rnd;
    bit                lng;
    rnd = $urandom;
    len = 32'(pat[LEN_W-1:0]);
    seq = pat[SEQ_LSB +: SEQ_W];
    if (len == 0) begin
      len = $urandom_range(1, 6);
      seq = rnd[SEQ_W-1:0];
    end
    if (len > HD) len = HD;
    mg = (cfg_min_gap > 150) ? 150 : cfg_min_gap;
    spoil = ($urandom_range(4) == 0) ? $urandom_range(1, len) : 0;
    g = (cfg_dead < 100000) ? cfg_dead + $urandom_range(1, 1000) : $urandom;
    send_knock(sent_ts + g, 1'b0, RES_REJECT);
    for (int unsigned j = 0; j < len; j++) begin
      lng = seq[j];
      if (j + 1 == spoil && $urandom_range(1) == 0) lng = !lng;
      g = lng ? $urandom_range(3*mg + 50, 3*mg + 250) : $urandom_range(mg + 1, mg + 1 + mg/4);
      if (j + 1 == spoil && lng == seq[j] && cfg_too_long < 32'h7000_0000)
        g = cfg_too_long + $urandom_range(1, 500);
      send_knock(sent_ts + g, 1'b0, RES_REJECT);
    end
  endtask

  task automatic send_noise();
    int unsigned mg;
    mg = (cfg_min_gap > 150) ? 150 : cfg_min_gap;
    if ($urandom_range(1) == 0) send_knock($urandom, 1'b0, RES_REJECT);
    else send_knock(sent_ts + $urandom_range(0, 2*mg + 10), 1'b0, RES_REJECT);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      seen = {res_if.accepted, res_if.matched, res_if.pattern_index};
      if (seen.accepted) n_appended++;
      if (seen.matched) n_matched++;
      if (due_outcomes.size() == 0) begin
        report_mismatch("result transfer with no knock outstanding");
      end else begin
        want = due_outcomes.pop_front();
        if (seen.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %b, want %b", seen.accepted, want.accepted));
        if (seen.matched !== want.matched)
          report_mismatch($sformatf("matched %b, want %b", seen.matched, want.matched));
        if (seen.pattern_index !== want.pattern_index)
          report_mismatch($sformatf("pattern_index %0d, want %0d",
                                    seen.pattern_index, want.pattern_index));
      end
    end
  end

  // result sink: random backpressure, one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      res_if.ready <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d results outstanding", due_outcomes.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int  start;
    int  target;
    bit  hold_done;
    bit  pause_done;
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    kn_if.valid      <= 1'b0;
    kn_if.knock_time <= '0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    sent_ts    = '0;
    model_reset();
    build_directed();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) begin
      if (directed[k].is_write) begin
        settle();
        write_reg(directed[k].reg_idx, directed[k].value);
      end else begin
        cfg_write <= 1'b0;
        send_knock(directed[k].value, directed[k].typed, directed[k].res);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      setup_phase(ph);
      cfg_write <= 1'b0;
      no_idle = (ph == 3);
      target  = (ph >= 5 && ph <= 7) ? 50 : 150;
      start   = items_sent;
      while (items_sent - start < target) begin
        if (ph == 2 && !hold_done && items_sent - start >= 40) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == 4 && !pause_done && items_sent - start >= 75) begin
          settle();
          pause_done = 1'b1;
        end
        if ($urandom_range(99) < 72) play_rhythm(cfg_pat[$urandom_range(NP - 1)]);
        else send_noise();
      end
    end
    no_idle = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_outcomes.size() != 0)
      report_mismatch($sformatf("%0d knock results never arrived", due_outcomes.size()));
    $display("Sent %0d knocks across %0d register settings: %0d appended, %0d rhythm matches.",
             items_sent, NUM_PHASES + 1, n_appended, n_matched);
    $display("Included wrap, deadtime edges, zero/saturated lengths and a %0d-cycle sink stall.",
             STALL_CYCLES);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
